// ===== sv/vtk_pkg.sv =====
// Shared types, codes and lookup functions for the VT100 key escape decoder.
`default_nettype none
package vtk_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_WAIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LATER_WAIT  = 2'd2;

    localparam logic [7:0] FIRST_WAIT_RST  = 8'd30;
    localparam logic [7:0] SECOND_WAIT_RST = 8'd50;
    localparam logic [7:0] LATER_WAIT_RST  = 8'd70;

    // decoder phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ESC   = 3'd1;
    localparam logic [2:0] PH_SS3   = 3'd2;
    localparam logic [2:0] PH_SS3_2 = 3'd3;
    localparam logic [2:0] PH_CSI   = 3'd4;
    localparam logic [2:0] PH_NUM   = 3'd5;
    localparam logic [2:0] PH_MOD   = 3'd6;

    localparam logic [5:0] K_ESC     = 6'd0;
    localparam logic [5:0] K_UP      = 6'd1;
    localparam logic [5:0] K_DOWN    = 6'd2;
    localparam logic [5:0] K_LEFT    = 6'd3;
    localparam logic [5:0] K_RIGHT   = 6'd4;
    localparam logic [5:0] K_INSERT  = 6'd5;
    localparam logic [5:0] K_DEL     = 6'd6;
    localparam logic [5:0] K_HOME    = 6'd7;
    localparam logic [5:0] K_END     = 6'd8;
    localparam logic [5:0] K_PGUP    = 6'd9;
    localparam logic [5:0] K_PGDN    = 6'd10;
    localparam logic [5:0] K_STAB    = 6'd11;
    localparam logic [5:0] K_F1      = 6'd12;
    localparam logic [5:0] K_SF3     = 6'd24;
    localparam logic [5:0] K_RAW     = 6'd34;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_R     = 8'h52;

    localparam int unsigned MAX_RES = 4;
    localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] timer;
        logic [7:0] key_num;
    } t_dec_state;

    typedef struct packed {
        logic [7:0] first_wait;
        logic [7:0] second_wait;
        logic [7:0] later_wait;
    } t_dec_cfg;

    typedef struct packed {
        logic [5:0] key_code;
        logic [7:0] raw_byte;
        logic       last;
    } t_res;

    typedef struct packed {
        t_res [MAX_RES-1:0]  item;
        logic [CNT_W-1:0]    cnt;
    } t_res_set;

    function automatic t_res mk_res(input logic [5:0] code, input logic [7:0] raw);
        t_res r;
        r.key_code = code;
        r.raw_byte = raw;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic [5:0] letter_key(input logic [7:0] b, input logic allow_z);
        logic [5:0] k;
        k = K_ESC;
        case (b)
            8'h41:   k = K_UP;
            8'h42:   k = K_DOWN;
            8'h43:   k = K_RIGHT;
            8'h44:   k = K_LEFT;
            8'h48:   k = K_HOME;
            8'h46:   k = K_END;
            8'h5A:   k = allow_z ? K_STAB : K_ESC;
            default: k = K_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] tilde_key(input logic [7:0] n);
        logic [5:0] k;
        k = K_ESC;
        case (n)
            8'd1:    k = K_HOME;
            8'd2:    k = K_INSERT;
            8'd3:    k = K_DEL;
            8'd4:    k = K_END;
            8'd5:    k = K_PGUP;
            8'd6:    k = K_PGDN;
            8'd11:   k = 6'd12;
            8'd12:   k = 6'd13;
            8'd13:   k = 6'd14;
            8'd14:   k = 6'd15;
            8'd15:   k = 6'd16;
            8'd17:   k = 6'd17;
            8'd18:   k = 6'd18;
            8'd19:   k = 6'd19;
            8'd20:   k = 6'd20;
            8'd21:   k = 6'd21;
            8'd23:   k = 6'd22;
            8'd24:   k = 6'd23;
            8'd25:   k = 6'd24;
            8'd26:   k = 6'd25;
            8'd28:   k = 6'd26;
            8'd29:   k = 6'd27;
            8'd31:   k = 6'd28;
            8'd32:   k = 6'd29;
            8'd33:   k = 6'd30;
            8'd34:   k = 6'd31;
            default: k = K_ESC;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vtk_if.sv =====
// Valid/ready channel interfaces for requests, results and register writes.
`default_nettype none
interface vtk_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    modport source (output valid, output mode, output rx_byte, input ready);
    modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface vtk_out_if;
    logic       valid;
    logic       ready;
    logic [5:0] key_code;
    logic [7:0] raw_byte;
    logic       last;
    modport source (output valid, output key_code, output raw_byte, output last, input ready);
    modport sink   (input valid, input key_code, input raw_byte, input last, output ready);
endinterface

interface vtk_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/vtk_step.sv =====
// Next-state and result logic for one decoder request.
`default_nettype none
module vtk_step (
    input  vtk_pkg::t_dec_state i_st,
    input  vtk_pkg::t_dec_cfg   i_cfg,
    input  logic                i_mode,
    input  logic [7:0]          i_byte,
    output vtk_pkg::t_dec_state o_st,
    output vtk_pkg::t_res_set   o_res
);
    import vtk_pkg::*;

    logic       digit;
    logic [3:0] dval;
    logic [11:0] prod;
    logic [7:0] limit;
    logic       fail_en;
    logic       with_b;
    logic       done_en;
    logic [5:0] done_code;
    logic       raw_en;
    logic [5:0] lk;

    assign digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign dval  = i_byte[3:0];
    assign prod  = {1'b0, i_st.key_num, 3'b000} + {3'b000, i_st.key_num, 1'b0}
                   + {8'd0, dval};

    always_comb begin
        o_st      = i_st;
        fail_en   = 1'b0;
        with_b    = 1'b0;
        done_en   = 1'b0;
        done_code = K_ESC;
        raw_en    = 1'b0;
        limit     = i_cfg.later_wait;
        lk        = K_ESC;
        if (i_mode) begin
            if (i_st.phase != PH_IDLE) begin
                if (i_st.timer != 8'hFF) begin
                    o_st.timer = i_st.timer + 8'd1;
                end
                case (i_st.phase) inside
                    PH_ESC:          limit = i_cfg.first_wait;
                    PH_SS3, PH_CSI:  limit = i_cfg.second_wait;
                    default:         limit = i_cfg.later_wait;
                endcase
                if (o_st.timer >= limit) begin
                    fail_en = 1'b1;
                end
            end
        end else begin
            o_st.timer = 8'd0;
            unique case (i_st.phase) inside
                PH_IDLE: begin
                    if (i_byte == CH_ESC) begin
                        o_st.phase   = PH_ESC;
                        o_st.key_num = 8'd0;
                    end else begin
                        raw_en = 1'b1;
                    end
                end
                PH_ESC: begin
                    if (i_byte == CH_O) begin
                        o_st.phase = PH_SS3;
                    end else if (i_byte == CH_LBRK) begin
                        o_st.phase = PH_CSI;
                    end else begin
                        fail_en = 1'b1;
                        with_b  = 1'b1;
                    end
                end
                PH_SS3: begin
                    if (i_byte >= CH_P && i_byte <= CH_T) begin
                        done_en   = 1'b1;
                        done_code = K_F1 + 6'(i_byte - CH_P);
                    end else if (i_byte == CH_TWO) begin
                        o_st.phase = PH_SS3_2;
                    end else begin
                        fail_en = 1'b1;
                        with_b  = 1'b1;
                    end
                end
                PH_SS3_2: begin
                    if (i_byte == CH_R) begin
                        done_en   = 1'b1;
                        done_code = K_SF3;
                    end else begin
                        fail_en = 1'b1;
                        with_b  = 1'b1;
                    end
                end
                PH_CSI: begin
                    lk = letter_key(i_byte, 1'b1);
                    if (lk != K_ESC) begin
                        done_en   = 1'b1;
                        done_code = lk;
                    end else if (digit) begin
                        o_st.key_num = {4'd0, dval};
                        o_st.phase   = PH_NUM;
                    end else begin
                        fail_en = 1'b1;
                        with_b  = 1'b1;
                    end
                end
                PH_NUM, PH_MOD: begin
                    lk = letter_key(i_byte, 1'b0);
                    if (digit) begin
                        if (i_st.phase == PH_NUM) begin
                            o_st.key_num = (prod > 12'd255) ? 8'hFF : prod[7:0];
                        end
                    end else if (i_byte == CH_SEMI && i_st.phase == PH_NUM) begin
                        o_st.phase = PH_MOD;
                    end else if (lk != K_ESC) begin
                        done_en   = 1'b1;
                        done_code = lk;
                    end else if (i_byte == CH_TILDE) begin
                        done_en   = 1'b1;
                        done_code = tilde_key(i_st.key_num);
                    end else begin
                        done_en   = 1'b1;
                        done_code = K_ESC;
                    end
                end
                default: begin
                    o_st.phase = PH_IDLE;
                end
            endcase
        end
        if (fail_en || done_en) begin
            o_st.phase = PH_IDLE;
        end
    end

    always_comb begin
        o_res = '0;
        if (raw_en) begin
            o_res.item[0] = mk_res(K_RAW, i_byte);
            o_res.cnt     = CNT_W'(1);
        end
        if (done_en) begin
            o_res.item[0] = mk_res(done_code, 8'd0);
            o_res.cnt     = CNT_W'(1);
        end
        if (fail_en) begin
            o_res.item[0] = mk_res(K_ESC, 8'd0);
            o_res.item[1] = mk_res(K_RAW, i_byte);
            o_res.cnt     = CNT_W'(1);
            case (i_st.phase)
                PH_ESC: begin
                    o_res.cnt = CNT_W'(1) + CNT_W'(with_b);
                end
                PH_SS3: begin
                    o_res.item[1] = mk_res(K_RAW, CH_O);
                    o_res.item[2] = mk_res(K_RAW, i_byte);
                    o_res.cnt     = CNT_W'(2) + CNT_W'(with_b);
                end
                PH_SS3_2: begin
                    o_res.item[1] = mk_res(K_RAW, CH_O);
                    o_res.item[2] = mk_res(K_RAW, CH_TWO);
                    o_res.item[3] = mk_res(K_RAW, i_byte);
                    o_res.cnt     = CNT_W'(3) + CNT_W'(with_b);
                end
                PH_CSI: begin
                    o_res.item[1] = mk_res(K_RAW, CH_LBRK);
                    o_res.item[2] = mk_res(K_RAW, i_byte);
                    o_res.cnt     = CNT_W'(2) + CNT_W'(with_b);
                end
                default: begin
                    o_res.cnt = CNT_W'(1);
                end
            endcase
        end
        for (int i = 0; i < MAX_RES; i++) begin
            o_res.item[i].last = (o_res.cnt == CNT_W'(i + 1));
        end
    end

endmodule
`default_nettype wire

// ===== sv/vt100_key_escape_decoder_top.sv =====
// Top level of the VT100 key escape decoder: state, registers and result queue.
//
//  channel  dir  payload                        handshake
//  i_in     in   mode, rx_byte                  valid/ready
//  o_out    out  key_code, raw_byte, last       valid/ready
//  i_cfg    in   index, data                    valid/ready (always ready)
//
// A request is decoded in the cycle it is taken; its 0..4 results are loaded
// into a four-entry result queue and leave one per cycle while the output
// is ready. A new request is taken while the last queued result is being
// handed over. Reset is synchronous; the wait registers return to 30/50/70.
// A stalled output holds the queue and blocks requests.
`default_nettype none
module vt100_key_escape_decoder_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    vtk_in_if.sink           i_in,
    vtk_out_if.source        o_out,
    vtk_cfg_if.sink          i_cfg
);
    import vtk_pkg::*;

    t_dec_state       r_st;
    t_dec_state       n_st;
    t_dec_cfg         r_cfg;
    t_res_set         n_set;
    t_res [MAX_RES-1:0] r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             in_take;
    logic             out_take;

    vtk_step u_step (
        .i_st   (r_st),
        .i_cfg  (r_cfg),
        .i_mode (i_in.mode),
        .i_byte (i_in.rx_byte),
        .o_st   (n_st),
        .o_res  (n_set)
    );

    assign i_cfg.ready = 1'b1;

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.key_code = r_q[0].key_code;
    assign o_out.raw_byte = r_q[0].raw_byte;
    assign o_out.last     = r_q[0].last;

    assign out_take    = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_out.ready);
    assign in_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_wait  <= FIRST_WAIT_RST;
            r_cfg.second_wait <= SECOND_WAIT_RST;
            r_cfg.later_wait  <= LATER_WAIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_FIRST_WAIT:  r_cfg.first_wait  <= i_cfg.data;
                REG_SECOND_WAIT: r_cfg.second_wait <= i_cfg.data;
                REG_LATER_WAIT:  r_cfg.later_wait  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase   <= PH_IDLE;
            r_st.timer   <= 8'd0;
            r_st.key_num <= 8'd0;
        end else if (in_take) begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_take) begin
            r_cnt <= n_set.cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_q <= n_set.item;
        end else if (out_take) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

endmodule
`default_nettype wire
